/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TLPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlpt assertion failed");

// Condition must never be seen outside reset.
`define TLPT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("tlpt forbidden condition seen");

`endif

/* rtl/tlpt_pkg.sv */
`default_nettype none
package tlpt_pkg;

  // Geometry
  localparam int IDX_W           = 10;
  localparam int DIR_ENTRIES     = 1024;
  localparam int TABLE_ENTRIES   = 1024;
  localparam int TABLE_SLOTS_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  // Stream widths (data fields padded to whole bytes)
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  // Entry bit positions
  localparam int E_PRESENT = 0;
  localparam int E_USER    = 2;
  localparam int E_HUGE    = 7;

  // Boot layout ranges
  localparam int LOW_END    = 64;
  localparam int NC_START   = 224;
  localparam int NC_END     = 256;
  localparam int MIRROR_LO  = 768;
  localparam int MIRROR_END = 832;

  // Request kinds
  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  // One classified request as it travels through the queue
  typedef struct packed {
    op_e         op;
    logic [31:0] virt;
    logic [19:0] frame;
    logic [11:0] flags;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // Directory contents after reset: 4 MB pages, identity mapped in the low and non-cacheable ranges, mirror aliases low
  function automatic logic [31:0] boot_pde(input logic [IDX_W-1:0] idx);
    logic [31:0] val;
    val = 32'h0;
    if (int'(idx) < LOW_END ||
        (int'(idx) >= MIRROR_LO && int'(idx) < MIRROR_END)) begin
      val = {4'h0, idx[5:0], 22'h0} | 32'h0000_0083;
    end else if (int'(idx) >= NC_START && int'(idx) < NC_END) begin
      val = {idx, 22'h0} | 32'h0000_0093;
    end
    return val;
  endfunction

endpackage
`default_nettype wire

/* rtl/tlpt_front.sv */
`default_nettype none
module tlpt_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [tlpt_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  wire logic [tlpt_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  wire logic                          ready_i,   // back end out of boot fill
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output tlpt_pkg::cmd_t                     q_cmd_o
);
  import tlpt_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Decode the operation code into a request kind
  always_comb begin
    cmd_d       = cmd_q;
    cmd_d.virt  = s_tdata_i[31:0];
    cmd_d.frame = s_tdata_i[63:44];
    cmd_d.flags = s_tdata_i[75:64];
    unique case (s_tuser_i)
      OP_MAP:   cmd_d.op = OP_MAP;
      OP_UNMAP: cmd_d.op = OP_UNMAP;
      OP_XLATE: cmd_d.op = OP_XLATE;
      default:  cmd_d.op = OP_BAD;
    endcase
  end

  // One holding stage in front of the queue
  assign q_push_o        = vld_q && !q_full_i;
  assign s_axis_tready_o = ready_i && (!vld_q || !q_full_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign q_cmd_o         = cmd_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/tlpt_fifo.sv */
`default_nettype none
`include "assert_macros.svh"
module tlpt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tlpt_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output tlpt_pkg::qhead_t    head_o
);
  import tlpt_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == CW'(QUEUE_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.cmd   = mem_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  `TLPT_ASSERT(a_fifo_bound, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH))
  `TLPT_ASSERT(a_fifo_pop_nonempty, clk_i, rst_ni, pop_i |-> (cnt_q != '0))

endmodule
`default_nettype wire

/* rtl/tlpt_back.sv */
`default_nettype none
`include "assert_macros.svh"
module tlpt_back #(
  parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tlpt_pkg::qhead_t              head_i,
  output logic                               pop_o,
  output logic                               ready_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [tlpt_pkg::M_TDATA_W-1:0]     m_tdata_o
);
  import tlpt_pkg::*;

  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int TAB_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIR   = 6'b000100,
    ST_CLEAR = 6'b001000,
    ST_MAPW  = 6'b010000,
    ST_PTE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  nfree_q, nfree_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  cmd_t              cur_q;

  // Memories
  logic [31:0]       dir_mem [DIR_ENTRIES];
  logic [31:0]       tab_mem [TAB_DEPTH];
  logic [31:0]       dir_rdata_q, tab_rdata_q;
  logic              dir_we, tab_we, tab_re;
  logic [IDX_W-1:0]  dir_waddr;
  logic [31:0]       dir_wdata, tab_wdata;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;

  // Result register
  logic        out_vld_q, out_vld_d;
  logic        status_q;
  logic [31:0] res_q;
  logic        res_set, res_status;
  logic [31:0] res_data;
  logic        out_free;

  // Decoded directory entry
  logic [31:0]       pde;
  logic              pde_vld, pde_big, slot_ok;
  logic [SLOT_W-1:0] pde_slot;
  logic [IDX_W-1:0]  ti;
  logic [31:0]       map_pte;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [IDX_W-1:0] i);
    return TAB_AW'({s, i});
  endfunction

  assign pde         = dir_rdata_q;
  assign pde_vld     = pde[E_PRESENT];
  assign pde_big     = pde[E_HUGE];
  assign slot_ok     = pde[31:12] < 20'(TABLE_SLOTS);
  assign pde_slot    = pde[12 +: SLOT_W];
  assign ti          = cur_q.virt[21:12];
  assign map_pte     = {cur_q.frame, cur_q.flags[11:1], 1'b1};

  assign out_free = !out_vld_q || m_axis_tready_i;
  assign pop_o    = (state_q == ST_IDLE) && head_i.valid && out_free;
  assign ready_o  = state_q != ST_INIT;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    nfree_d    = nfree_q;
    slot_d     = slot_q;
    dir_we     = 1'b0;
    dir_waddr  = cur_q.virt[31:22];
    dir_wdata  = {20'(nfree_q), 9'h0, cur_q.flags[E_USER], 2'b11};
    tab_we     = 1'b0;
    tab_waddr  = tab_addr(pde_slot, ti);
    tab_wdata  = map_pte;
    tab_re     = 1'b0;
    tab_raddr  = tab_addr(pde_slot, ti);
    res_set    = 1'b0;
    res_status = 1'b0;
    res_data   = 32'h0;
    unique case (state_q)
      ST_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = cnt_q;
        dir_wdata = boot_pde(cnt_q);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(DIR_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_DIR;
        end
      end
      ST_DIR: begin
        state_d = ST_IDLE;
        case (cur_q.op)
          OP_MAP: begin
            if (pde_vld) begin
              res_set = 1'b1;
              if (!pde_big && slot_ok) begin
                tab_we = 1'b1;
              end else begin
                res_status = 1'b1;
              end
            end else if (nfree_q < CNT_W'(TABLE_SLOTS)) begin
              // take a fresh table and clear it
              dir_we  = 1'b1;
              slot_d  = SLOT_W'(nfree_q);
              nfree_d = nfree_q + 1'b1;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              res_set    = 1'b1;
              res_status = 1'b1;
            end
          end
          OP_UNMAP: begin
            res_set = 1'b1;
            if (pde_vld && !pde_big && slot_ok) begin
              tab_we    = 1'b1;
              tab_wdata = 32'h0;
            end
          end
          OP_XLATE: begin
            if (!pde_vld) begin
              res_set    = 1'b1;
              res_status = 1'b1;
            end else if (pde_big) begin
              res_set  = 1'b1;
              res_data = {pde[31:22], cur_q.virt[21:0]};
            end else if (slot_ok) begin
              tab_re  = 1'b1;
              state_d = ST_PTE;
            end else begin
              res_set    = 1'b1;
              res_status = 1'b1;
            end
          end
          default: begin
            res_set    = 1'b1;
            res_status = 1'b1;
          end
        endcase
      end
      ST_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = tab_addr(slot_q, cnt_q);
        tab_wdata = 32'h0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = ST_MAPW;
        end
      end
      ST_MAPW: begin
        tab_we    = 1'b1;
        tab_waddr = tab_addr(slot_q, ti);
        res_set   = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_PTE: begin
        res_set = 1'b1;
        state_d = ST_IDLE;
        if (tab_rdata_q[E_PRESENT]) begin
          res_data = {tab_rdata_q[31:12], cur_q.virt[11:0]};
        end else begin
          res_status = 1'b1;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Output beat holding
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_set) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      nfree_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      nfree_q   <= nfree_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (pop_o) begin
      cur_q <= head_i.cmd;
    end
    if (res_set) begin
      status_q <= res_status;
      res_q    <= res_data;
    end
  end

  // Directory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dir_rdata_q <= dir_mem[head_i.cmd.virt[31:22]];
    end
  end

  // Table pool: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_tdata_o       = {7'h0, res_q, status_q};

  `TLPT_ASSERT(a_nfree_bound, clk_i, rst_ni, nfree_q <= CNT_W'(TABLE_SLOTS))
  `TLPT_ASSERT(a_alloc_clears, clk_i, rst_ni, (nfree_q != $past(nfree_q)) |-> (state_q == ST_CLEAR))
  `TLPT_NEVER(a_result_overrun, clk_i, rst_ni, res_set && out_vld_q)

endmodule
`default_nettype wire

/* rtl/two_level_page_table_store_top.sv */
// Flow: an accepted request is registered in the front holding stage, then queued; the back
// end pops it in idle with a registered directory read and resolves it in the directory
// state, a walk through a table adding a registered table read in the PTE state. A map that
// allocates a table first sweeps that table clear. Results are registered on the output. The
// back end finishes one request before popping the next; the front stage and queue hold more.
// Reset: the directory is filled with the boot layout, with tready low.
`default_nettype none
module two_level_page_table_store_top #(
  parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] virt_addr, [63:32] phys_addr, [75:64] map_flags, [79:76] zero
  input  wire logic [tlpt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [tlpt_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] status, [32:1] phys_result, [39:33] zero
  output logic [tlpt_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);
  import tlpt_pkg::*;

  logic   ready;
  logic   q_full, q_push, q_pop;
  cmd_t   q_cmd;
  qhead_t q_head;

  tlpt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_tdata_i       (s_axis_tdata_i),
    .s_tuser_i       (s_axis_tuser_i),
    .ready_i         (ready),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd)
  );

  tlpt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  tlpt_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .ready_o         (ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_tdata_o       (m_axis_tdata_o)
  );

endmodule
`default_nettype wire
